### rtl/core/bte_pkg.sv
// Shared types, codes and defaults for the bookmark table edit tracker.
// Used by bookmark_table_edit_tracker_top and bte_adjust; depends on nothing.
package bte_pkg;

   localparam int MARK_ENTRIES_DEF  = 32;
   localparam int POSITION_BITS_DEF = 24;

   localparam int OPCODE_W = 2;
   localparam int LABEL_W  = 8;
   localparam int SEL_W    = 2;
   localparam int STATUS_W = 2;

   typedef enum logic [OPCODE_W-1:0] {
      OP_ADD       = 2'd0,
      OP_GOTO      = 2'd1,
      OP_GOTO_EXT  = 2'd2,
      OP_EDIT      = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   localparam logic [SEL_W-1:0] SEL_NONE  = 2'd0;
   localparam logic [SEL_W-1:0] SEL_PLAIN = 2'd1;
   localparam logic [SEL_W-1:0] SEL_RECT  = 2'd2;
   localparam logic [SEL_W-1:0] SEL_ALT   = 2'd3;

   // fold a..z to A..Z, leave every other byte alone
   function automatic logic [LABEL_W-1:0] fold_label(input logic [LABEL_W-1:0] c);
      logic [LABEL_W-1:0] r;
      r = c;
      if (c >= 8'h61 && c <= 8'h7a) begin
         r = c - 8'h20;
      end
      return r;
   endfunction

endpackage

### rtl/core/bte_adjust.sv
// Per-entry position update across one buffer edit (insert and/or delete).
// Depends on bte_pkg for selection codes.
module bte_adjust #(
   parameter int POSITION_BITS = bte_pkg::POSITION_BITS_DEF
) (
   input  logic [bte_pkg::SEL_W-1:0] sel_state,
   input  logic [POSITION_BITS-1:0]  start_pos,
   input  logic [POSITION_BITS-1:0]  end_pos,
   input  logic [POSITION_BITS-1:0]  cursor_pos,
   input  logic [POSITION_BITS-1:0]  edit_pos,
   input  logic [POSITION_BITS-1:0]  inserted_count,
   input  logic [POSITION_BITS-1:0]  deleted_count,
   output logic [bte_pkg::SEL_W-1:0] new_sel_state,
   output logic [POSITION_BITS-1:0]  new_start,
   output logic [POSITION_BITS-1:0]  new_end,
   output logic [POSITION_BITS-1:0]  new_cursor
);
   import bte_pkg::*;

   localparam int PB = POSITION_BITS;

   function automatic logic [PB-1:0] adj(
      input logic [PB-1:0] p,
      input logic [PB-1:0] at,
      input logic [PB-1:0] ins,
      input logic [PB-1:0] del
   );
      logic [PB:0]   lim;
      logic [PB:0]   r;
      logic [PB-1:0] res;
      lim = {1'b0, at} + {1'b0, del};
      r   = {1'b0, p} - {1'b0, del} + {1'b0, ins};
      if (at > p) begin
         res = p;
      end else if (lim <= {1'b0, p}) begin
         res = r[PB] ? {PB{1'b1}} : r[PB-1:0];
      end else begin
         res = at;
      end
      return res;
   endfunction

   logic [PB-1:0] adj_start;
   logic [PB-1:0] adj_end;
   logic          touch_sel;

   assign adj_start = adj(start_pos, edit_pos, inserted_count, deleted_count);
   assign adj_end   = adj(end_pos, edit_pos, inserted_count, deleted_count);
   assign touch_sel = (sel_state != SEL_NONE) && (edit_pos <= end_pos);

   always_comb begin
      new_sel_state = sel_state;
      new_start     = start_pos;
      new_end       = end_pos;
      if (touch_sel) begin
         new_start = adj_start;
         new_end   = adj_end;
         if (adj_end <= adj_start) begin
            new_sel_state = SEL_NONE;
         end
      end
   end

   assign new_cursor = adj(cursor_pos, edit_pos, inserted_count, deleted_count);

endmodule

### rtl/core/bookmark_table_edit_tracker_top.sv
// Labelled bookmark table: add mark, goto mark (plain or extending), buffer edit.
// Depends on bte_pkg and bte_adjust; the table is one synchronous RAM in here.
//
// Usage:
//   req_* is the item channel (valid/ready); one beat carries opcode, label, the
//   current selection and cursor, and the edit position and counts. rsp_* is the
//   result channel (valid/ready); every item gives exactly one result beat.
//   Entries sit in one RAM with a registered read port. Each item walks the
//   stored entries in order, one per cycle through that port: lookups stop at
//   the first label match, edits read, adjust and write back every entry.
//   When the walk ends the result is registered into rsp_*, and req_ready rises
//   in the same cycle as rsp_valid, so the next item can be taken while that
//   result beat is still offered.
//   req_ready is high only while no item is in work. A result beat held by a
//   stalled receiver does not block the next accept; that item is worked and
//   then held until the pending beat is taken.
//   Reset clears the entry count, the control state and rsp_valid; the RAM
//   contents are not cleared, since no entry beyond the count is ever read.
module bookmark_table_edit_tracker_top #(
   parameter int MARK_ENTRIES  = bte_pkg::MARK_ENTRIES_DEF,
   parameter int POSITION_BITS = bte_pkg::POSITION_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [bte_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [bte_pkg::LABEL_W-1:0]  req_label,
   input  logic [bte_pkg::SEL_W-1:0]    req_sel_state,
   input  logic [bte_pkg::SEL_W-1:0]    req_sel_type,
   input  logic [POSITION_BITS-1:0]     req_sel_start,
   input  logic [POSITION_BITS-1:0]     req_sel_end,
   input  logic [POSITION_BITS-1:0]     req_rect_left,
   input  logic [POSITION_BITS-1:0]     req_rect_right,
   input  logic [POSITION_BITS-1:0]     req_cursor_pos,
   input  logic [POSITION_BITS-1:0]     req_edit_pos,
   input  logic [POSITION_BITS-1:0]     req_inserted_count,
   input  logic [POSITION_BITS-1:0]     req_deleted_count,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [bte_pkg::STATUS_W-1:0] rsp_status,
   output logic [bte_pkg::SEL_W-1:0]    rsp_out_sel_state,
   output logic [bte_pkg::SEL_W-1:0]    rsp_out_sel_type,
   output logic [POSITION_BITS-1:0]     rsp_out_start,
   output logic [POSITION_BITS-1:0]     rsp_out_end,
   output logic [POSITION_BITS-1:0]     rsp_out_rect_left,
   output logic [POSITION_BITS-1:0]     rsp_out_rect_right,
   output logic [POSITION_BITS-1:0]     rsp_out_cursor
);
   import bte_pkg::*;

   localparam int PB        = POSITION_BITS;
   localparam int IDX_W     = (MARK_ENTRIES > 1) ? $clog2(MARK_ENTRIES) : 1;
   localparam int CNT_W     = $clog2(MARK_ENTRIES + 1);
   localparam int CUR_LSB   = 0;
   localparam int RR_LSB    = PB;
   localparam int RL_LSB    = 2 * PB;
   localparam int END_LSB   = 3 * PB;
   localparam int START_LSB = 4 * PB;
   localparam int TY_LSB    = 5 * PB;
   localparam int ST_LSB    = 5 * PB + SEL_W;
   localparam int LAB_LSB   = 5 * PB + 2 * SEL_W;
   localparam int ENTRY_W   = 5 * PB + 2 * SEL_W + LABEL_W;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W-1:0]   scan_idx_ff, scan_idx_in;
   logic               chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               hit_ff, hit_in;
   logic               full_ff, full_in;
   logic [ENTRY_W-1:0] hit_data_ff, hit_data_in;
   logic [ENTRY_W-1:0] rd_data_ff;

   opcode_type         op_ff, op_in;
   logic [LABEL_W-1:0] lab_ff, lab_in;
   logic [SEL_W-1:0]   st_ff, st_in;
   logic [SEL_W-1:0]   ty_ff, ty_in;
   logic [PB-1:0]      s_ff, s_in;
   logic [PB-1:0]      e_ff, e_in;
   logic [PB-1:0]      rl_ff, rl_in;
   logic [PB-1:0]      rr_ff, rr_in;
   logic [PB-1:0]      cur_ff, cur_in;
   logic [PB-1:0]      at_ff, at_in;
   logic [PB-1:0]      ins_ff, ins_in;
   logic [PB-1:0]      del_ff, del_in;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [SEL_W-1:0]   rsp_st_ff, rsp_st_in;
   logic [SEL_W-1:0]   rsp_ty_ff, rsp_ty_in;
   logic [PB-1:0]      rsp_start_ff, rsp_start_in;
   logic [PB-1:0]      rsp_end_ff, rsp_end_in;
   logic [PB-1:0]      rsp_rl_ff, rsp_rl_in;
   logic [PB-1:0]      rsp_rr_ff, rsp_rr_in;
   logic [PB-1:0]      rsp_cur_ff, rsp_cur_in;

   logic [ENTRY_W-1:0] entry_mem [MARK_ENTRIES];
   logic               mem_we;
   logic [IDX_W-1:0]   mem_wa;
   logic [ENTRY_W-1:0] mem_wd;
   logic [IDX_W-1:0]   mem_ra;

   logic               req_fire;
   logic               issue;
   logic               match_now;
   logic               scan_done;
   logic               table_full;
   logic               rsp_free;

   logic [LABEL_W-1:0] rd_label;
   logic [SEL_W-1:0]   rd_st;
   logic [SEL_W-1:0]   rd_ty;
   logic [PB-1:0]      rd_start, rd_end, rd_rl, rd_rr, rd_cur;
   logic [SEL_W-1:0]   adj_st;
   logic [PB-1:0]      adj_start, adj_end, adj_cur;

   logic [SEL_W-1:0]   h_st;
   logic [SEL_W-1:0]   h_ty;
   logic [PB-1:0]      h_start, h_end, h_rl, h_rr, h_cur;
   logic [PB-1:0]      os, oe, ns, ne;

   assign rd_label = rd_data_ff[LAB_LSB +: LABEL_W];
   assign rd_st    = rd_data_ff[ST_LSB +: SEL_W];
   assign rd_ty    = rd_data_ff[TY_LSB +: SEL_W];
   assign rd_start = rd_data_ff[START_LSB +: PB];
   assign rd_end   = rd_data_ff[END_LSB +: PB];
   assign rd_rl    = rd_data_ff[RL_LSB +: PB];
   assign rd_rr    = rd_data_ff[RR_LSB +: PB];
   assign rd_cur   = rd_data_ff[CUR_LSB +: PB];

   assign h_st    = hit_data_ff[ST_LSB +: SEL_W];
   assign h_ty    = hit_data_ff[TY_LSB +: SEL_W];
   assign h_start = hit_data_ff[START_LSB +: PB];
   assign h_end   = hit_data_ff[END_LSB +: PB];
   assign h_rl    = hit_data_ff[RL_LSB +: PB];
   assign h_rr    = hit_data_ff[RR_LSB +: PB];
   assign h_cur   = hit_data_ff[CUR_LSB +: PB];

   bte_adjust #(
      .POSITION_BITS(POSITION_BITS)
   ) u_adjust (
      .sel_state     (rd_st),
      .start_pos     (rd_start),
      .end_pos       (rd_end),
      .cursor_pos    (rd_cur),
      .edit_pos      (at_ff),
      .inserted_count(ins_ff),
      .deleted_count (del_ff),
      .new_sel_state (adj_st),
      .new_start     (adj_start),
      .new_end       (adj_end),
      .new_cursor    (adj_cur)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign table_full = (count_ff == CNT_W'(MARK_ENTRIES));
   assign issue      = (state_ff == ST_SCAN) && (scan_idx_ff < count_ff);
   assign match_now  = chk_valid_ff && (op_ff != OP_EDIT) && (rd_label == lab_ff);
   assign scan_done  = (state_ff == ST_SCAN) && (match_now || (!chk_valid_ff && !issue));
   assign mem_ra     = scan_idx_ff[IDX_W-1:0];

   // table write port: edit write-back or add
   always_comb begin
      mem_we = 1'b0;
      mem_wa = chk_idx_ff;
      mem_wd = {lab_ff, st_ff, ty_ff, s_ff, e_ff, rl_ff, rr_ff, cur_ff};
      if (state_ff == ST_SCAN) begin
         if (op_ff == OP_EDIT) begin
            mem_we = chk_valid_ff;
            mem_wd = {rd_label, adj_st, rd_ty, adj_start, adj_end, rd_rl, rd_rr, adj_cur};
         end else if (op_ff == OP_ADD && scan_done) begin
            mem_we = match_now || !table_full;
            if (!match_now) begin
               mem_wa = count_ff[IDX_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= entry_mem[mem_ra];
   end

   // control and captured item
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      scan_idx_in  = scan_idx_ff;
      chk_valid_in = 1'b0;
      chk_idx_in   = chk_idx_ff;
      hit_in       = hit_ff;
      full_in      = full_ff;
      hit_data_in  = hit_data_ff;
      op_in  = op_ff;
      lab_in = lab_ff;
      st_in  = st_ff;
      ty_in  = ty_ff;
      s_in   = s_ff;
      e_in   = e_ff;
      rl_in  = rl_ff;
      rr_in  = rr_ff;
      cur_in = cur_ff;
      at_in  = at_ff;
      ins_in = ins_ff;
      del_in = del_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in       = opcode_type'(req_opcode);
               lab_in      = fold_label(req_label);
               st_in       = (req_sel_state == SEL_ALT) ? SEL_PLAIN : req_sel_state;
               ty_in       = req_sel_type;
               s_in        = req_sel_start;
               e_in        = req_sel_end;
               rl_in       = req_rect_left;
               rr_in       = req_rect_right;
               cur_in      = req_cursor_pos;
               at_in       = req_edit_pos;
               ins_in      = req_inserted_count;
               del_in      = req_deleted_count;
               scan_idx_in = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue && !scan_done) begin
               scan_idx_in  = scan_idx_ff + CNT_W'(1);
               chk_valid_in = 1'b1;
               chk_idx_in   = scan_idx_ff[IDX_W-1:0];
            end
            if (scan_done) begin
               hit_in      = match_now;
               hit_data_in = rd_data_ff;
               full_in     = table_full && !match_now;
               if (op_ff == OP_ADD && !match_now && !table_full) begin
                  count_in = count_ff + CNT_W'(1);
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result build
   always_comb begin
      os = (st_ff != SEL_NONE) ? s_ff : cur_ff;
      oe = (st_ff != SEL_NONE) ? e_ff : cur_ff;
      ns = (h_st != SEL_NONE) ? h_start : h_cur;
      ne = (h_st != SEL_NONE) ? h_end : h_cur;
      rsp_status_in = STATUS_OK;
      rsp_st_in     = SEL_NONE;
      rsp_ty_in     = '0;
      rsp_start_in  = '0;
      rsp_end_in    = '0;
      rsp_rl_in     = '0;
      rsp_rr_in     = '0;
      rsp_cur_in    = '0;
      case (op_ff)
         OP_ADD: begin
            rsp_status_in = full_ff ? STATUS_FULL : STATUS_OK;
         end
         OP_GOTO, OP_GOTO_EXT: begin
            if (!hit_ff) begin
               rsp_status_in = STATUS_NOT_FOUND;
            end else begin
               rsp_cur_in = h_cur;
               if (op_ff == OP_GOTO_EXT) begin
                  rsp_st_in    = SEL_PLAIN;
                  rsp_start_in = (os < ns) ? os : ns;
                  rsp_end_in   = (oe > ne) ? oe : ne;
               end else if (h_st == SEL_RECT) begin
                  rsp_st_in    = SEL_RECT;
                  rsp_start_in = h_start;
                  rsp_end_in   = h_end;
                  rsp_rl_in    = h_rl;
                  rsp_rr_in    = h_rr;
               end else if (h_st != SEL_NONE) begin
                  rsp_st_in    = SEL_PLAIN;
                  rsp_ty_in    = h_ty;
                  rsp_start_in = h_start;
                  rsp_end_in   = h_end;
               end
            end
         end
         default: begin
            rsp_status_in = STATUS_OK;
         end
      endcase
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (state_ff == ST_FINISH && rsp_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      chk_idx_ff  <= chk_idx_in;
      hit_ff      <= hit_in;
      full_ff     <= full_in;
      hit_data_ff <= hit_data_in;
      op_ff       <= op_in;
      lab_ff      <= lab_in;
      st_ff       <= st_in;
      ty_ff       <= ty_in;
      s_ff        <= s_in;
      e_ff        <= e_in;
      rl_ff       <= rl_in;
      rr_ff       <= rr_in;
      cur_ff      <= cur_in;
      at_ff       <= at_in;
      ins_ff      <= ins_in;
      del_ff      <= del_in;
      if (state_ff == ST_FINISH && rsp_free) begin
         rsp_status_ff <= rsp_status_in;
         rsp_st_ff     <= rsp_st_in;
         rsp_ty_ff     <= rsp_ty_in;
         rsp_start_ff  <= rsp_start_in;
         rsp_end_ff    <= rsp_end_in;
         rsp_rl_ff     <= rsp_rl_in;
         rsp_rr_ff     <= rsp_rr_in;
         rsp_cur_ff    <= rsp_cur_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_out_sel_state  = rsp_st_ff;
   assign rsp_out_sel_type   = rsp_ty_ff;
   assign rsp_out_start      = rsp_start_ff;
   assign rsp_out_end        = rsp_end_ff;
   assign rsp_out_rect_left  = rsp_rl_ff;
   assign rsp_out_rect_right = rsp_rr_ff;
   assign rsp_out_cursor     = rsp_cur_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MARK_ENTRIES))
      else $error("entry count beyond table depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("entry count moved by other than one");

   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == ST_SCAN)
      else $error("table write outside scan");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_SCAN)
      else $error("accepted beat did not start a scan");

   a_check_in_scan: assert property (@(posedge clock) disable iff (reset)
      chk_valid_ff |-> state_ff == ST_SCAN)
      else $error("read data checked outside scan");

endmodule
